FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Types and constants of the coalesced hash map core.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int TABLE_SIZE_DEF = 64;
  localparam int KEY_W          = 31;
  localparam int VAL_W          = 32;

  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  localparam logic [VAL_W-1:0] NOT_FOUND = {VAL_W{1'b1}};

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } chm_in_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic             table_full;
  } chm_out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } chm_slot_t;

endpackage

FILE: design/coalesced_hash_map_core.sv
// Table-full inserts and unknown commands answer from idle; search and erase
//   follow the chain link by link; insert fills a free home slot, else probes
//   one slot a cycle or evicts a foreign occupant via ST_EV_STP and ST_EV_CHK.
// Throughput: one word at a time; any busy period ends with the result strobe.
// Reset (rst_n, synchronous): used and link-valid bits and the fill count clear
//   at once; no clearing pass. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
// coalesced_hash_map_core
// Key/value map on coalesced chains, kept in a slot memory and a link memory.
// ----------------------------------------------------------------------------
module coalesced_hash_map_core
  import chm_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  chm_in_t  in_data,
  output logic     out_strobe,
  output chm_out_t out_data
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = AW + 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_S_CHK  = 4'd1;
  localparam logic [3:0] ST_I_HOME = 4'd2;
  localparam logic [3:0] ST_I_HCHK = 4'd3;
  localparam logic [3:0] ST_EV_STP = 4'd4;
  localparam logic [3:0] ST_EV_CHK = 4'd5;
  localparam logic [3:0] ST_EV_SWP = 4'd6;
  localparam logic [3:0] ST_PROBE  = 4'd7;
  localparam logic [3:0] ST_PLINK  = 4'd8;
  localparam logic [3:0] ST_E_HCHK = 4'd9;
  localparam logic [3:0] ST_E_PULL = 4'd10;
  localparam logic [3:0] ST_E_CHK  = 4'd11;

  localparam logic [AW-1:0] STEP_LAST  = {AW{1'b1}};
  localparam logic [CW-1:0] ROUND_OVER = CW'(TABLE_SIZE + 1);

  // Slot memories: key/value and chain link, one shared read address.
  chm_slot_t       dmem [TABLE_SIZE];
  logic [AW-1:0]   lmem [TABLE_SIZE];
  chm_slot_t       rd_slot_r;
  logic [AW-1:0]   rd_link_r;

  logic [AW-1:0]   raddr;
  logic            dwe;
  logic [AW-1:0]   dwaddr;
  chm_slot_t       dwdata;
  logic            lwe;
  logic [AW-1:0]   lwaddr;
  logic [AW-1:0]   lwdata;

  logic [3:0]            state_r, state_nxt;
  logic [TABLE_SIZE-1:0] used_r, used_nxt;
  logic [TABLE_SIZE-1:0] lok_r, lok_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [VAL_W-1:0]      val_r, val_nxt;
  logic [KEY_W-1:0]      ek_r, ek_nxt;
  logic [VAL_W-1:0]      ev_r, ev_nxt;
  logic [AW-1:0]         h_r, h_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         prev_r, prev_nxt;
  logic [AW-1:0]         step_r, step_nxt;
  logic [CW-1:0]         round_r, round_nxt;
  logic [AW-1:0]         link_h_r, link_h_nxt;
  logic                  lok_h_r, lok_h_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  chm_out_t              out_r, out_nxt;

  logic [AW-1:0] in_home;
  logic [AW-1:0] key_home;
  logic [AW-1:0] rd_home;
  logic          key_hit;

  assign in_home  = in_data.key[AW-1:0];
  assign key_home = key_r[AW-1:0];
  assign rd_home  = rd_slot_r.key[AW-1:0];
  assign key_hit  = (rd_slot_r.key == key_r);

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    lok_nxt        = lok_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    ek_nxt         = ek_r;
    ev_nxt         = ev_r;
    h_nxt          = h_r;
    idx_nxt        = idx_r;
    prev_nxt       = prev_r;
    step_nxt       = step_r;
    round_nxt      = round_r;
    link_h_nxt     = link_h_r;
    lok_h_nxt      = lok_h_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    raddr          = idx_r;
    dwe            = 1'b0;
    dwaddr         = h_r;
    dwdata         = '{key: key_r, value: val_r};
    lwe            = 1'b0;
    lwaddr         = h_r;
    lwdata         = link_h_r;

    unique case (state_r)
      ST_IDLE: begin
        raddr = in_home;
        if (start) begin
          key_nxt  = in_data.key;
          val_nxt  = in_data.value;
          h_nxt    = in_home;
          idx_nxt  = in_home;
          step_nxt = '0;
          // Default word: miss, no value.
          out_nxt  = '{found: 1'b0, value_out: NOT_FOUND, table_full: 1'b0};
          unique case (in_data.command)
            CMD_SEARCH: state_nxt = ST_S_CHK;
            CMD_ERASE:  state_nxt = ST_E_HCHK;
            CMD_INSERT: begin
              if (cnt_r >= CW'(TABLE_SIZE)) begin
                // Reject and leave the table alone.
                out_nxt.table_full = 1'b1;
                out_strobe_nxt     = 1'b1;
              end else begin
                round_nxt = '0;
                state_nxt = ST_I_HOME;
              end
            end
            default: out_strobe_nxt = 1'b1;
          endcase
        end
      end

      // Search: one chain link per cycle, next read issued from the link.
      ST_S_CHK: begin
        if (used_r[idx_r] && key_hit) begin
          out_nxt.found     = 1'b1;
          out_nxt.value_out = rd_slot_r.value;
          out_strobe_nxt    = 1'b1;
          state_nxt         = ST_IDLE;
        end else if (!lok_r[idx_r] || step_r == STEP_LAST) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          idx_nxt  = rd_link_r;
          raddr    = rd_link_r;
          step_nxt = step_r + 1'b1;
        end
      end

      ST_I_HOME: begin
        h_nxt = key_home;
        raddr = key_home;
        if (round_r == ROUND_OVER) begin
          out_nxt.found  = 1'b1;
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (!used_r[key_home]) begin
          // Free home slot: fill it.
          dwe                = 1'b1;
          dwaddr             = key_home;
          used_nxt[key_home] = 1'b1;
          cnt_nxt            = cnt_r + 1'b1;
          out_nxt.found      = 1'b1;
          out_strobe_nxt     = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          state_nxt = ST_I_HCHK;
        end
      end

      ST_I_HCHK: begin
        link_h_nxt = rd_link_r;
        lok_h_nxt  = lok_r[h_r];
        step_nxt   = '0;
        if (rd_home != h_r) begin
          // Foreign occupant: unlink it from its own chain, then swap.
          ek_nxt    = rd_slot_r.key;
          ev_nxt    = rd_slot_r.value;
          idx_nxt   = rd_home;
          state_nxt = ST_EV_STP;
        end else begin
          idx_nxt   = AW'({h_r, 1'b1});
          state_nxt = ST_PROBE;
        end
      end

      ST_EV_STP: begin
        raddr = idx_r;
        if (!lok_r[idx_r]) state_nxt = ST_EV_SWP;
        else               state_nxt = ST_EV_CHK;
      end

      ST_EV_CHK: begin
        if (rd_link_r == h_r) begin
          lwe            = 1'b1;
          lwaddr         = idx_r;
          lwdata         = link_h_r;
          lok_nxt[idx_r] = lok_h_r;
          state_nxt      = ST_EV_SWP;
        end else if (step_r == STEP_LAST) begin
          state_nxt = ST_EV_SWP;
        end else begin
          idx_nxt   = rd_link_r;
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_EV_STP;
        end
      end

      ST_EV_SWP: begin
        dwe          = 1'b1;
        dwaddr       = h_r;
        lok_nxt[h_r] = 1'b0;
        key_nxt      = ek_r;
        val_nxt      = ev_r;
        round_nxt    = round_r + 1'b1;
        state_nxt    = ST_I_HOME;
      end

      // Probe one slot a cycle from 2*home+1, wrapping.
      ST_PROBE: begin
        if (!used_r[idx_r]) begin
          dwe             = 1'b1;
          dwaddr          = idx_r;
          used_nxt[idx_r] = 1'b1;
          cnt_nxt         = cnt_r + 1'b1;
          lwe             = 1'b1;
          lwaddr          = idx_r;
          lwdata          = link_h_r;
          lok_nxt[idx_r]  = lok_h_r;
          state_nxt       = ST_PLINK;
        end else if (step_r == STEP_LAST) begin
          out_nxt.found  = 1'b1;
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          idx_nxt  = idx_r + 1'b1;
          step_nxt = step_r + 1'b1;
        end
      end

      ST_PLINK: begin
        lwe            = 1'b1;
        lwaddr         = h_r;
        lwdata         = idx_r;
        lok_nxt[h_r]   = 1'b1;
        out_nxt.found  = 1'b1;
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_E_HCHK: begin
        if (used_r[h_r] && key_hit) begin
          if (!lok_r[h_r]) begin
            used_nxt[h_r]  = 1'b0;
            cnt_nxt        = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
            out_nxt.found  = 1'b1;
            out_strobe_nxt = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            // Pull the next entry into the head slot.
            raddr     = rd_link_r;
            idx_nxt   = rd_link_r;
            state_nxt = ST_E_PULL;
          end
        end else if (!lok_r[h_r]) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          prev_nxt  = h_r;
          raddr     = rd_link_r;
          idx_nxt   = rd_link_r;
          step_nxt  = '0;
          state_nxt = ST_E_CHK;
        end
      end

      ST_E_PULL: begin
        dwe          = 1'b1;
        dwaddr       = h_r;
        dwdata       = rd_slot_r;
        lwe          = 1'b1;
        lwaddr       = h_r;
        lwdata       = rd_link_r;
        used_nxt[h_r] = used_r[idx_r];
        lok_nxt[h_r]  = lok_r[idx_r];
        if (idx_r != h_r) begin
          used_nxt[idx_r] = 1'b0;
          lok_nxt[idx_r]  = 1'b0;
        end
        cnt_nxt        = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
        out_nxt.found  = 1'b1;
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_E_CHK: begin
        if (used_r[idx_r] && key_hit) begin
          used_nxt[idx_r] = 1'b0;
          lwe             = 1'b1;
          lwaddr          = prev_r;
          lwdata          = rd_link_r;
          lok_nxt[prev_r] = lok_r[idx_r];
          lok_nxt[idx_r]  = 1'b0;
          cnt_nxt         = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
          out_nxt.found   = 1'b1;
          out_strobe_nxt  = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (!lok_r[idx_r] || step_r == STEP_LAST) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          prev_nxt = idx_r;
          idx_nxt  = rd_link_r;
          raddr    = rd_link_r;
          step_nxt = step_r + 1'b1;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memories: registered read, one write port each.
  always_ff @(posedge clk) begin
    rd_slot_r <= dmem[raddr];
    rd_link_r <= lmem[raddr];
    if (dwe) dmem[dwaddr] <= dwdata;
    if (lwe) lmem[lwaddr] <= lwdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      lok_r        <= '0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      lok_r        <= lok_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    ek_r     <= ek_nxt;
    ev_r     <= ev_nxt;
    h_r      <= h_nxt;
    idx_r    <= idx_nxt;
    prev_r   <= prev_nxt;
    step_r   <= step_nxt;
    round_r  <= round_nxt;
    link_h_r <= link_h_nxt;
    lok_h_r  <= lok_h_nxt;
    out_r    <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`include "assert_macros.svh"

  `CHK_NEXT(a_start_progress, start && !busy, busy || out_strobe_r)
  `CHK_IMPL(a_strobe_idle, out_strobe_r, state_r == ST_IDLE)
  `CHK_IMPL(a_count_bound, 1'b1, cnt_r <= CW'(TABLE_SIZE))
  `CHK_IMPL(a_full_no_found, out_strobe_r && out_r.table_full, !out_r.found)

endmodule
